>>> hdl/mfb_pkg.sv
package mfb_pkg;

    localparam int DEFAULT_PANEL_WIDTH  = 104;
    localparam int DEFAULT_PANEL_HEIGHT = 212;

    localparam logic [7:0] WHITE_BYTE = 8'hFF;
    localparam logic [7:0] BLACK_BYTE = 8'h00;
    localparam logic [7:0] LEFT_PIXEL_MASK = 8'h80;

    typedef enum logic [2:0] {
        MODE_PIXEL      = 3'd0,
        MODE_RECT_WHITE = 3'd1,
        MODE_RECT_BLACK = 3'd2,
        MODE_IMAGE      = 3'd3,
        MODE_RAW        = 3'd4,
        MODE_READ       = 3'd5,
        MODE_CLEAR      = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_MODIFY,
        ST_READ,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // one command word as taken from the input channel
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [7:0] width_px;
        logic [7:0] height_rows;
        logic       pixel_on;
        logic [7:0] data_byte;
    } item_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic set_clip;
        logic clr_step;
        logic fill_step;
        logic byte_write;
        logic pix_write;
        logic capture_rd;
        logic out_load;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] mode;
        logic       pix_ok;
        logic       byte_ok;
        logic       fill_empty;
        logic       fill_last;
        logic       clr_last;
        logic       out_free;
    } status_t;

    function automatic logic [7:0] reverse_bits(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

endpackage

>>> hdl/mfb_cmd_if.sv
interface mfb_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] width_px;
    logic [7:0] height_rows;
    logic       pixel_on;
    logic [7:0] data_byte;

    modport source (
        output valid, mode, x_pos, y_pos, width_px, height_rows, pixel_on, data_byte,
        input  ready
    );

    modport sink (
        input  valid, mode, x_pos, y_pos, width_px, height_rows, pixel_on, data_byte,
        output ready
    );
endinterface

>>> hdl/mfb_rsp_if.sv
interface mfb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       clipped;

    modport source (
        output valid, read_data, clipped,
        input  ready
    );

    modport sink (
        input  valid, read_data, clipped,
        output ready
    );
endinterface

>>> hdl/mono_framebuffer_engine.sv
// 1-bit-per-pixel frame store for an e-paper panel, PANEL_HEIGHT rows of
// PANEL_WIDTH/8 bytes held in one single-port-write memory, pixels packed
// msb first, 0 is ink and 1 is white. each command word on cmd does one
// operation and gives exactly one response word on rsp: set or clear a
// pixel, fill a byte-aligned rectangle white or black, store an image byte
// (bit-reversed and inverted) or a raw byte, read a byte, or clear the whole
// store to white. anything that falls outside the store is dropped and
// flagged by clipped; read_data is zero except for a successful read.
// after reset the block sweeps all (PANEL_WIDTH/8)*PANEL_HEIGHT bytes
// (2756 at 104 x 212) to white, one byte per cycle; cmd.ready stays low
// until that sweep is done. one word is in work at a time. the memory
// read is registered, so a pixel update reads its byte in one cycle and
// writes it back in the next; a rectangle is written one byte per cycle
// and a clear all repeats the whole-store sweep. the response register
// lets the next word be taken while the previous response is still
// waiting; a response still stalled when the next word is done holds
// the engine in its last step.
module mono_framebuffer_engine #(
    parameter int PANEL_WIDTH  = mfb_pkg::DEFAULT_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfb_pkg::DEFAULT_PANEL_HEIGHT
) (
    input  logic          clk,
    input  logic          rst_n,
    mfb_cmd_if.sink       cmd,
    mfb_rsp_if.source     rsp
);

    mfb_pkg::item_t   item;
    mfb_pkg::ctrl_t   ctl;
    mfb_pkg::status_t stat;

    // command word fields, gathered for the datapath
    assign item.mode        = cmd.mode;
    assign item.x_pos       = cmd.x_pos;
    assign item.y_pos       = cmd.y_pos;
    assign item.width_px    = cmd.width_px;
    assign item.height_rows = cmd.height_rows;
    assign item.pixel_on    = cmd.pixel_on;
    assign item.data_byte   = cmd.data_byte;

    // sequencer: decodes the mode and steps the sweeps
    mfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // frame store, address math, counters and response register
    mfb_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .read_data (rsp.read_data),
        .clipped   (rsp.clipped)
    );

`ifndef SYNTH
    // a taken word keeps the engine busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command accepted while previous one still in work");

    // no store write happens while waiting for a command
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !(ctl.clr_step || ctl.fill_step || ctl.byte_write || ctl.pix_write))
        else $error("store written while idle");

    // the response register is never overwritten while it holds a word
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!rsp.valid || rsp.ready))
        else $error("pending response overwritten");
`endif

endmodule

>>> hdl/mfb_ctrl.sv
module mfb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  mfb_pkg::status_t  stat,
    output mfb_pkg::ctrl_t    ctl
);

    mfb_pkg::state_t state_reg;
    mfb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfb_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        cmd_ready  = 1'b0;
        case (state_reg)
            mfb_pkg::ST_INIT:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = mfb_pkg::ST_IDLE;
                end
            end
            mfb_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = mfb_pkg::ST_EXEC;
                end
            end
            mfb_pkg::ST_EXEC:
            begin
                state_next = mfb_pkg::ST_DONE;
                case (stat.mode)
                    mfb_pkg::MODE_PIXEL:
                    begin
                        if (stat.pix_ok)
                        begin
                            state_next = mfb_pkg::ST_MODIFY;
                        end
                        else
                        begin
                            ctl.set_clip = 1'b1;
                        end
                    end
                    mfb_pkg::MODE_RECT_WHITE,
                    mfb_pkg::MODE_RECT_BLACK:
                    begin
                        if (!stat.fill_empty)
                        begin
                            state_next = mfb_pkg::ST_FILL;
                        end
                    end
                    mfb_pkg::MODE_IMAGE,
                    mfb_pkg::MODE_RAW:
                    begin
                        if (stat.byte_ok)
                        begin
                            ctl.byte_write = 1'b1;
                        end
                        else
                        begin
                            ctl.set_clip = 1'b1;
                        end
                    end
                    mfb_pkg::MODE_READ:
                    begin
                        if (stat.byte_ok)
                        begin
                            state_next = mfb_pkg::ST_READ;
                        end
                        else
                        begin
                            ctl.set_clip = 1'b1;
                        end
                    end
                    mfb_pkg::MODE_CLEAR:
                    begin
                        state_next = mfb_pkg::ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = mfb_pkg::ST_DONE;
                    end
                endcase
            end
            mfb_pkg::ST_MODIFY:
            begin
                ctl.pix_write = 1'b1;
                state_next    = mfb_pkg::ST_DONE;
            end
            mfb_pkg::ST_READ:
            begin
                ctl.capture_rd = 1'b1;
                state_next     = mfb_pkg::ST_DONE;
            end
            mfb_pkg::ST_FILL:
            begin
                ctl.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = mfb_pkg::ST_DONE;
                end
            end
            mfb_pkg::ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = mfb_pkg::ST_DONE;
                end
            end
            mfb_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = mfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mfb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/mfb_datapath.sv
module mfb_datapath #(
    parameter int PANEL_WIDTH  = mfb_pkg::DEFAULT_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfb_pkg::DEFAULT_PANEL_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mfb_pkg::item_t    item,
    input  mfb_pkg::ctrl_t    ctl,
    output mfb_pkg::status_t  stat,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output logic [7:0]        read_data,
    output logic              clipped
);

    localparam int ROW_BYTES   = PANEL_WIDTH / 8;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW          = $clog2(STORE_BYTES + 1);

    // command word
    logic [2:0] mode_reg,  mode_next;
    logic [7:0] x_reg,     x_next;
    logic [7:0] y_reg,     y_next;
    logic [7:0] w_reg,     w_next;
    logic [7:0] h_reg,     h_next;
    logic       on_reg,    on_next;
    logic [7:0] data_reg,  data_next;

    // result in progress
    logic       clip_reg,  clip_next;
    logic [7:0] rd_reg,    rd_next;

    // sweep counters
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [4:0]    col_cnt_reg, col_cnt_next;
    logic [7:0]    row_cnt_reg, row_cnt_next;

    // output stage
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg,  out_data_next;
    logic       out_clip_reg,  out_clip_next;

    // frame store
    logic [7:0]    store_mem [STORE_BYTES];
    logic [7:0]    rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] byte_addr;

    logic [4:0]    fill_cols;
    logic [5:0]    fill_col;
    logic [8:0]    fill_row;
    logic          fill_in;
    logic [AW-1:0] fill_addr;
    logic          col_end;
    logic [7:0]    pix_mask;
    logic [7:0]    fill_value;
    logic [7:0]    byte_value;

    always_comb
    begin
        fill_cols = w_reg[7:3];
        fill_col  = {1'b0, x_reg[7:3]} + {1'b0, col_cnt_reg};
        fill_row  = {1'b0, y_reg} + {1'b0, row_cnt_reg};
        fill_in   = (fill_col < 6'(ROW_BYTES)) && (fill_row < 9'(PANEL_HEIGHT));
        fill_addr = AW'(fill_row[7:0]) * AW'(ROW_BYTES) + AW'(fill_col[4:0]);
        byte_addr = AW'(y_reg) * AW'(ROW_BYTES) + AW'(x_reg[7:3]);
        col_end   = (col_cnt_reg == 5'(fill_cols - 5'd1));
        pix_mask  = mfb_pkg::LEFT_PIXEL_MASK >> x_reg[2:0];

        fill_value = (mode_reg == mfb_pkg::MODE_RECT_BLACK) ? mfb_pkg::BLACK_BYTE
                                                            : mfb_pkg::WHITE_BYTE;
        byte_value = (mode_reg == mfb_pkg::MODE_IMAGE) ? ~mfb_pkg::reverse_bits(data_reg)
                                                       : data_reg;

        stat.mode       = mode_reg;
        stat.byte_ok    = ({1'b0, x_reg[7:3]} < 6'(ROW_BYTES))
                          && ({1'b0, y_reg} < 9'(PANEL_HEIGHT));
        stat.pix_ok     = stat.byte_ok && ({1'b0, x_reg} < 9'(PANEL_WIDTH));
        stat.fill_empty = (fill_cols == 5'd0) || (h_reg == 8'd0);
        stat.fill_last  = col_end && (row_cnt_reg == 8'(h_reg - 8'd1));
        stat.clr_last   = (clr_cnt_reg == AW'(STORE_BYTES - 1));
        stat.out_free   = !out_valid_reg || rsp_ready;
    end

    // one write port shared by clear, fill, byte write and pixel update
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = byte_addr;
        mem_wdata = byte_value;
        if (ctl.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = mfb_pkg::WHITE_BYTE;
        end
        else if (ctl.fill_step)
        begin
            mem_we    = fill_in;
            mem_waddr = fill_addr;
            mem_wdata = fill_value;
        end
        else if (ctl.byte_write)
        begin
            mem_we = 1'b1;
        end
        else if (ctl.pix_write)
        begin
            mem_we    = 1'b1;
            mem_wdata = on_reg ? (rdata_reg & ~pix_mask) : (rdata_reg | pix_mask);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= store_mem[byte_addr];
    end

    always_comb
    begin
        mode_next      = mode_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        on_next        = on_reg;
        data_next      = data_reg;
        clip_next      = clip_reg;
        rd_next        = rd_reg;
        clr_cnt_next   = clr_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_clip_next  = out_clip_reg;

        if (ctl.load_item)
        begin
            mode_next    = item.mode;
            x_next       = item.x_pos;
            y_next       = item.y_pos;
            w_next       = item.width_px;
            h_next       = item.height_rows;
            on_next      = item.pixel_on;
            data_next    = item.data_byte;
            clip_next    = 1'b0;
            rd_next      = 8'd0;
            clr_cnt_next = '0;
            col_cnt_next = 5'd0;
            row_cnt_next = 8'd0;
        end

        if (ctl.set_clip)
        begin
            clip_next = 1'b1;
        end

        if (ctl.capture_rd)
        begin
            rd_next = rdata_reg;
        end

        if (ctl.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        if (ctl.fill_step)
        begin
            if (!fill_in)
            begin
                clip_next = 1'b1;
            end
            if (col_end)
            begin
                col_cnt_next = 5'd0;
                row_cnt_next = row_cnt_reg + 8'd1;
            end
            else
            begin
                col_cnt_next = col_cnt_reg + 5'd1;
            end
        end

        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = rd_reg;
            out_clip_next  = clip_reg;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            col_cnt_reg   <= 5'd0;
            row_cnt_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        on_reg       <= on_next;
        data_reg     <= data_next;
        clip_reg     <= clip_next;
        rd_reg       <= rd_next;
        out_data_reg <= out_data_next;
        out_clip_reg <= out_clip_next;
    end

    assign rsp_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign clipped   = out_clip_reg;

endmodule

>>> dv/mfb_checker.sv
`timescale 1ns / 100ps

module mfb_checker #(
    parameter int PANEL_WIDTH  = mfb_pkg::DEFAULT_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfb_pkg::DEFAULT_PANEL_HEIGHT
) (
    input  logic clk,
    input  logic rst_n,
    mfb_cmd_if   cmd,
    mfb_rsp_if   rsp,
    output int   fail_count,
    output int   pending_count,
    output int   words_checked
);
    import mfb_pkg::*;

    localparam int ROW_BYTES   = PANEL_WIDTH / 8;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped;
    } response_t;

    typedef struct packed {
        item_t     word;
        response_t resp;
    } expectation_t;

    logic [7:0]   shadow_store [0:STORE_BYTES-1];
    expectation_t expected_q [$];
    int           fails;
    int           checked;

    function automatic bit locate_byte(input int col, input int row, output int idx);
        idx = 0;
        if (col >= ROW_BYTES || row >= PANEL_HEIGHT)
            return 1'b0;
        idx = row * ROW_BYTES + col;
        return 1'b1;
    endfunction

    // writes every in-store byte of the rectangle, reports whether any fell out
    function automatic logic fill_block(input item_t w, input logic [7:0] value);
        logic clip;
        int   idx;
        clip = 1'b0;
        for (int r = 0; r < int'(w.height_rows); r++)
        begin
            for (int c = 0; c < int'(w.width_px) / 8; c++)
            begin
                if (locate_byte(int'(w.x_pos) / 8 + c, int'(w.y_pos) + r, idx))
                    shadow_store[idx] = value;
                else
                    clip = 1'b1;
            end
        end
        return clip;
    endfunction

    function automatic response_t apply_command(input item_t w);
        response_t  r;
        int         idx;
        logic [7:0] mask;
        logic [7:0] mirrored;
        r = '0;
        case (w.mode)
            MODE_PIXEL:
            begin
                if (int'(w.x_pos) < PANEL_WIDTH
                    && locate_byte(int'(w.x_pos) / 8, int'(w.y_pos), idx))
                begin
                    mask = LEFT_PIXEL_MASK >> w.x_pos[2:0];
                    if (w.pixel_on)
                        shadow_store[idx] = shadow_store[idx] & ~mask;
                    else
                        shadow_store[idx] = shadow_store[idx] | mask;
                end
                else
                    r.clipped = 1'b1;
            end
            MODE_RECT_WHITE: r.clipped = fill_block(w, WHITE_BYTE);
            MODE_RECT_BLACK: r.clipped = fill_block(w, BLACK_BYTE);
            MODE_IMAGE:
            begin
                if (locate_byte(int'(w.x_pos) / 8, int'(w.y_pos), idx))
                begin
                    for (int i = 0; i < 8; i++)
                        mirrored[7 - i] = w.data_byte[i];
                    shadow_store[idx] = ~mirrored;
                end
                else
                    r.clipped = 1'b1;
            end
            MODE_RAW:
            begin
                if (locate_byte(int'(w.x_pos) / 8, int'(w.y_pos), idx))
                    shadow_store[idx] = w.data_byte;
                else
                    r.clipped = 1'b1;
            end
            MODE_READ:
            begin
                if (locate_byte(int'(w.x_pos) / 8, int'(w.y_pos), idx))
                    r.read_data = shadow_store[idx];
                else
                    r.clipped = 1'b1;
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < STORE_BYTES; i++)
                    shadow_store[i] = WHITE_BYTE;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        expectation_t oldest;
        item_t        seen;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_BYTES; i++)
                shadow_store[i] = WHITE_BYTE;
            expected_q.delete();
            fails = 0;
            checked = 0;
            fail_count <= 0;
            pending_count <= 0;
            words_checked <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: response word with none expected: read_data %h clipped %b",
                             $time, rsp.read_data, rsp.clipped);
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    checked++;
                    if (rsp.read_data !== oldest.resp.read_data)
                    begin
                        fails++;
                        $display("%0t: mode %0d at %0d,%0d read_data expected %h, got %h",
                                 $time, oldest.word.mode, oldest.word.x_pos,
                                 oldest.word.y_pos, oldest.resp.read_data, rsp.read_data);
                    end
                    if (rsp.clipped !== oldest.resp.clipped)
                    begin
                        fails++;
                        $display("%0t: mode %0d at %0d,%0d clipped expected %b, got %b",
                                 $time, oldest.word.mode, oldest.word.x_pos,
                                 oldest.word.y_pos, oldest.resp.clipped, rsp.clipped);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                seen.mode        = cmd.mode;
                seen.x_pos       = cmd.x_pos;
                seen.y_pos       = cmd.y_pos;
                seen.width_px    = cmd.width_px;
                seen.height_rows = cmd.height_rows;
                seen.pixel_on    = cmd.pixel_on;
                seen.data_byte   = cmd.data_byte;
                oldest.word = seen;
                oldest.resp = apply_command(seen);
                expected_q.push_back(oldest);
            end
            fail_count <= fails;
            pending_count <= expected_q.size();
            words_checked <= checked;
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import mfb_pkg::*;

    localparam int PANEL_WIDTH  = DEFAULT_PANEL_WIDTH;
    localparam int PANEL_HEIGHT = DEFAULT_PANEL_HEIGHT;

    // mode 7 has no name in the package: the block must ignore it
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam int RANDOM_WORDS  = 1125;
    localparam int SETTLE_CYCLES = 16;
    // watchdog limit, meant to lie above the slowest legal run, reset sweep included
    localparam int CYCLE_LIMIT   = 1000000;

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   fail_count;
    int   pending_count;
    int   words_checked;
    int   mode_count [0:7];

    // last written location, reused by about half of the random reads so they land on fresh data
    logic [7:0] last_x;
    logic [7:0] last_y;

    // receiver stall pattern, rotated every cycle and replaced now and then
    logic [15:0] stall_pattern;
    int          pattern_age = 0;

    mfb_cmd_if cmd ();
    mfb_rsp_if rsp ();

    mono_framebuffer_engine #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    mfb_checker #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake or a lost response ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d responses outstanding",
                     cycle_count, pending_count);
            $display("mono_framebuffer_engine verification failed");
            $finish;
        end
    end

    // response side: phases of no stalls, random stalls and long stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pattern = 16'hFFFF;
                    1: stall_pattern = 16'($urandom) | 16'h0001;
                    2: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
                    default: stall_pattern = 16'h0001;
                endcase
                pattern_age = $urandom_range(48, 200);
            end
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            pattern_age--;
            rsp.ready <= stall_pattern[0];
        end
    end

    function automatic item_t make_word(input logic [2:0] mode, input int x, input int y,
                                        input int w, input int h, input logic on,
                                        input int data);
        item_t word;
        word.mode        = mode;
        word.x_pos       = 8'(x);
        word.y_pos       = 8'(y);
        word.width_px    = 8'(w);
        word.height_rows = 8'(h);
        word.pixel_on    = on;
        word.data_byte   = 8'(data);
        return word;
    endfunction

    // column biased to the panel, its right edge, and now and then anywhere
    function automatic logic [7:0] pick_col();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(PANEL_WIDTH - 8,
                                        (PANEL_WIDTH + 7 > 255) ? 255 : PANEL_WIDTH + 7));
            default: return 8'($urandom_range(0, PANEL_WIDTH - 1));
        endcase
    endfunction

    function automatic logic [7:0] pick_row();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range((PANEL_HEIGHT < 4) ? 0 : PANEL_HEIGHT - 4,
                                        (PANEL_HEIGHT + 3 > 255) ? 255 : PANEL_HEIGHT + 3));
            default: return 8'($urandom_range(0, PANEL_HEIGHT - 1));
        endcase
    endfunction

    function automatic item_t random_word();
        item_t word;
        int    pick;
        int    shape;
        // every field gets random content, the chosen mode then shapes the relevant ones
        word = make_word(3'($urandom_range(0, 7)), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 25)
            word.mode = MODE_PIXEL;
        else if (pick < 33)
            word.mode = MODE_RECT_WHITE;
        else if (pick < 41)
            word.mode = MODE_RECT_BLACK;
        else if (pick < 53)
            word.mode = MODE_IMAGE;
        else if (pick < 65)
            word.mode = MODE_RAW;
        else if (pick < 95)
            word.mode = MODE_READ;
        else if (pick < 97)
            word.mode = MODE_CLEAR;
        else
            word.mode = MODE_UNUSED;

        if (word.mode != MODE_CLEAR && word.mode != MODE_UNUSED)
        begin
            word.x_pos = pick_col();
            word.y_pos = pick_row();
        end

        // rectangles stay small, a handful span the full field range
        if (word.mode == MODE_RECT_WHITE || word.mode == MODE_RECT_BLACK)
        begin
            shape = $urandom_range(0, 99);
            if (shape >= 12)
            begin
                word.width_px    = 8'($urandom_range(0, 48));
                word.height_rows = 8'($urandom_range(0, 12));
            end
            else if (shape >= 2)
                word.height_rows = 8'($urandom_range(0, 3));
        end

        if (word.mode == MODE_PIXEL || word.mode == MODE_IMAGE || word.mode == MODE_RAW)
        begin
            last_x = word.x_pos;
            last_y = word.y_pos;
        end
        else if (word.mode == MODE_READ && $urandom_range(0, 1) == 1)
        begin
            word.x_pos = last_x;
            word.y_pos = last_y;
        end
        return word;
    endfunction

    // present one command word and hold it until the block takes it
    task automatic send_word(input item_t word);
        cmd.valid       <= 1'b1;
        cmd.mode        <= word.mode;
        cmd.x_pos       <= word.x_pos;
        cmd.y_pos       <= word.y_pos;
        cmd.width_px    <= word.width_px;
        cmd.height_rows <= word.height_rows;
        cmd.pixel_on    <= word.pixel_on;
        cmd.data_byte   <= word.data_byte;
        do
            @(posedge clk);
        while (!cmd.ready);
        mode_count[word.mode]++;
    endtask

    // stop sending until every response word is back, then let the block settle
    task automatic drain_responses();
        cmd.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        item_t directed_words [$];
        item_t word;
        int    random_sent;
        int    burst_left;
        int    gap;

        random_sent = 0;
        burst_left = 0;
        last_x = '0;
        last_y = '0;
        for (int i = 0; i < 8; i++)
            mode_count[i] = 0;

        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.mode = MODE_PIXEL;
        cmd.x_pos = '0;
        cmd.y_pos = '0;
        cmd.width_px = '0;
        cmd.height_rows = '0;
        cmd.pixel_on = 1'b0;
        cmd.data_byte = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners, clipping on each axis, every mode, empty and partial rectangles
        directed_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 1'b0, 0));
        directed_words.push_back(make_word(MODE_PIXEL, 0, 0, 0, 0, 1'b1, 0));
        directed_words.push_back(make_word(MODE_READ, 7, 0, 0, 0, 1'b0, 0));
        directed_words.push_back(make_word(MODE_PIXEL, PANEL_WIDTH - 1, PANEL_HEIGHT - 1,
                                           0, 0, 1'b1, 0));
        directed_words.push_back(make_word(MODE_READ, PANEL_WIDTH - 8, PANEL_HEIGHT - 1,
                                           0, 0, 1'b0, 0));
        directed_words.push_back(make_word(MODE_PIXEL, 0, 0, 0, 0, 1'b0, 0));
        // pixels just past the right edge, just below the bottom, and at the far corner
        directed_words.push_back(make_word(MODE_PIXEL, PANEL_WIDTH, 0, 0, 0, 1'b1, 0));
        directed_words.push_back(make_word(MODE_PIXEL, 0, PANEL_HEIGHT, 0, 0, 1'b1, 0));
        directed_words.push_back(make_word(MODE_PIXEL, 255, 255, 255, 255, 1'b1, 255));
        directed_words.push_back(make_word(MODE_IMAGE, 8, 1, 0, 0, 1'b0, 8'h01));
        directed_words.push_back(make_word(MODE_READ, 15, 1, 0, 0, 1'b0, 0));
        directed_words.push_back(make_word(MODE_IMAGE, 255, 0, 0, 0, 1'b0, 8'hFF));
        directed_words.push_back(make_word(MODE_RAW, PANEL_WIDTH - 8, PANEL_HEIGHT - 1,
                                           0, 0, 1'b0, 8'hA5));
        directed_words.push_back(make_word(MODE_READ, PANEL_WIDTH - 1, PANEL_HEIGHT - 1,
                                           0, 0, 1'b0, 0));
        directed_words.push_back(make_word(MODE_RAW, PANEL_WIDTH, 5, 0, 0, 1'b0, 8'h00));
        // reads outside the store return zero data
        directed_words.push_back(make_word(MODE_READ, PANEL_WIDTH, 0, 0, 0, 1'b0, 0));
        directed_words.push_back(make_word(MODE_READ, 0, PANEL_HEIGHT, 0, 0, 1'b0, 0));
        // whole panel black, then a rectangle hanging off the bottom right corner
        directed_words.push_back(make_word(MODE_RECT_BLACK, 0, 0, PANEL_WIDTH, PANEL_HEIGHT,
                                           1'b0, 0));
        directed_words.push_back(make_word(MODE_READ, 48, 100, 0, 0, 1'b0, 0));
        directed_words.push_back(make_word(MODE_RECT_WHITE, PANEL_WIDTH - 8, PANEL_HEIGHT - 2,
                                           32, 5, 1'b0, 0));
        // empty rectangles: too narrow, and zero rows
        directed_words.push_back(make_word(MODE_RECT_WHITE, 0, 0, 7, 5, 1'b0, 0));
        directed_words.push_back(make_word(MODE_RECT_BLACK, 0, 0, 16, 0, 1'b0, 0));
        directed_words.push_back(make_word(MODE_UNUSED, 255, 255, 255, 255, 1'b1, 255));
        directed_words.push_back(make_word(MODE_RECT_WHITE, 0, 0, 255, 255, 1'b0, 0));
        directed_words.push_back(make_word(MODE_CLEAR, 0, 0, 0, 0, 1'b0, 0));
        directed_words.push_back(make_word(MODE_READ, PANEL_WIDTH - 8, PANEL_HEIGHT - 1,
                                           0, 0, 1'b0, 0));

        // directed words go back to back with no idle cycles
        foreach (directed_words[i])
            send_word(directed_words[i]);
        drain_responses();

        // random part: bursts of words separated by gaps of varying length
        while (random_sent < RANDOM_WORDS)
        begin
            if (burst_left == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: gap = 0;
                    9: gap = $urandom_range(10, 30);
                    default: gap = $urandom_range(1, 4);
                endcase
                if (gap != 0)
                begin
                    cmd.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
                // now and then let the pipeline empty completely
                if ($urandom_range(0, 39) == 0)
                    drain_responses();
            end
            word = random_word();
            send_word(word);
            burst_left--;
            if (word.mode != MODE_UNUSED)
                random_sent++;
        end

        drain_responses();

        $display("covered %0d pixel, %0d rectangle, %0d image, %0d raw, %0d read words",
                 mode_count[MODE_PIXEL],
                 mode_count[MODE_RECT_WHITE] + mode_count[MODE_RECT_BLACK],
                 mode_count[MODE_IMAGE], mode_count[MODE_RAW], mode_count[MODE_READ]);
        $display("plus %0d clear and %0d unused-mode words; %0d responses compared in %0d cycles",
                 mode_count[MODE_CLEAR], mode_count[MODE_UNUSED], words_checked, cycle_count);
        if (fail_count == 0)
            $display("mono_framebuffer_engine verification clean");
        else
            $display("mono_framebuffer_engine verification failed");
        $finish;
    end

endmodule
